### design/spcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcp_pkg
// shared types and constants of the star prefixed command parser
// ----------------------------------------------------------------------------
package spcp_pkg;

   localparam int unsigned TIME_LEN = 6;
   localparam int unsigned TIME_W   = 8 * TIME_LEN;

   localparam logic [7:0] CHAR_STAR = 8'h2A;
   localparam logic [7:0] CHAR_E    = 8'h45;
   localparam logic [7:0] CHAR_R    = 8'h52;
   localparam logic [7:0] CHAR_S    = 8'h53;
   localparam logic [7:0] CHAR_T    = 8'h54;

   localparam logic [2:0] CMD_STARS     = 3'd5;
   localparam logic [2:0] STAR_MAX      = 3'd6;
   localparam logic [2:0] TIME_POS_LAST = 3'(TIME_LEN - 1);

   typedef enum logic [1:0] {
      EV_ERASE = 2'd0,
      EV_READ  = 2'd1,
      EV_TIME  = 2'd2,
      EV_STATE = 2'd3
   } event_code_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } byte_item_type;

   typedef struct packed {
      logic              valid;
      event_code_type    code;
      logic [TIME_W-1:0] time_data;
   } result_type;

endpackage

### design/spcp_input_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcp_input_reg
// input register for received bytes
// ----------------------------------------------------------------------------
module spcp_input_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  advance,
   output spcp_pkg::byte_item_type item
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;
   logic       load;

   assign req_tready = !valid_ff || advance;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_tdata;
      end
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;

endmodule

### design/spcp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcp_parser
// star counting, command decode and time capture
// ----------------------------------------------------------------------------
module spcp_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  spcp_pkg::byte_item_type item,
   input  logic                    advance,
   output spcp_pkg::result_type    result
);

   logic [2:0] stars_ff;
   logic [2:0] stars_in;
   logic       capturing_ff;
   logic       capturing_in;
   logic [2:0] pos_ff;
   logic [2:0] pos_in;
   logic [spcp_pkg::TIME_LEN-1:0][7:0] time_bytes_ff;
   logic [spcp_pkg::TIME_LEN-1:0][7:0] time_bytes_in;
   logic fire;

   assign fire = item.valid && advance;

   always_comb begin
      stars_in      = stars_ff;
      capturing_in  = capturing_ff;
      pos_in        = pos_ff;
      time_bytes_in = time_bytes_ff;
      result.valid     = 1'b0;
      result.code      = spcp_pkg::EV_ERASE;
      result.time_data = '0;
      if (capturing_ff) begin
         if (pos_ff <= spcp_pkg::TIME_POS_LAST) begin
            time_bytes_in[pos_ff] = item.data;
         end
         if (pos_ff == spcp_pkg::TIME_POS_LAST) begin
            result.valid     = fire;
            result.code      = spcp_pkg::EV_TIME;
            result.time_data = time_bytes_in;
            capturing_in     = 1'b0;
            pos_in           = 3'd0;
            // first time byte is looked at again with a cleared count
            stars_in = (time_bytes_in[0] == spcp_pkg::CHAR_STAR) ? 3'd1 : 3'd0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end else if (item.data == spcp_pkg::CHAR_STAR) begin
         if (stars_ff < spcp_pkg::STAR_MAX) begin
            stars_in = stars_ff + 3'd1;
         end
      end else if (stars_ff == spcp_pkg::CMD_STARS) begin
         unique case (item.data)
            spcp_pkg::CHAR_E: begin
               result.valid = fire;
               result.code  = spcp_pkg::EV_ERASE;
               stars_in     = 3'd0;
            end
            spcp_pkg::CHAR_R: begin
               result.valid = fire;
               result.code  = spcp_pkg::EV_READ;
               stars_in     = 3'd0;
            end
            spcp_pkg::CHAR_S: begin
               result.valid = fire;
               result.code  = spcp_pkg::EV_STATE;
               stars_in     = 3'd0;
            end
            spcp_pkg::CHAR_T: begin
               capturing_in = 1'b1;
               pos_in       = 3'd0;
            end
            default: begin
               stars_in = stars_ff;
            end
         endcase
      end else begin
         stars_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stars_ff     <= 3'd0;
         capturing_ff <= 1'b0;
         pos_ff       <= 3'd0;
      end else if (fire) begin
         stars_ff     <= stars_in;
         capturing_ff <= capturing_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         time_bytes_ff <= time_bytes_in;
      end
   end

endmodule

### design/spcp_output_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcp_output_reg
// result register toward the event channel
// ----------------------------------------------------------------------------
module spcp_output_reg (
   input  logic                        clock,
   input  logic                        reset,
   input  spcp_pkg::result_type        result,
   output logic                        advance,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [spcp_pkg::TIME_W-1:0] rsp_tdata,
   output logic [1:0]                  rsp_tuser
);

   logic                        valid_ff;
   logic                        valid_in;
   spcp_pkg::event_code_type    code_ff;
   logic [spcp_pkg::TIME_W-1:0] data_ff;

   assign advance  = !valid_ff || rsp_tready;
   assign valid_in = advance ? result.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         code_ff <= result.code;
         data_ff <= result.time_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = code_ff;

endmodule

### design/star_prefixed_command_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// star_prefixed_command_parser
// parses star prefixed command bytes into erase, read, time and state events
// ----------------------------------------------------------------------------
//  channel | direction | tdata                             | tuser
//  req     | in        | rx_byte                           | -
//  rsp     | out       | year month day hour minute second | event_code
//
//  one byte per cycle sustained unless rsp stalls; an accepted byte is held in
//  the input register and its event in the result register; throughput is set
//  by the single pass through the parser between the input and result registers
//  reset clears the star count, the capture state and both valid flags
//  a stalled event holds the result register; req stalls once input is full
// ----------------------------------------------------------------------------
module star_prefixed_command_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // year, month, day, hour, minute, second
   output logic [1:0]  rsp_tuser    // event_code
);

   spcp_pkg::byte_item_type item;
   spcp_pkg::result_type    result;
   logic                    advance;

   spcp_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .item       (item)
   );

   spcp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .item    (item),
      .advance (advance),
      .result  (result)
   );

   spcp_output_reg u_output_reg (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### design/spcp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcp_checker
// port level checks of the star prefixed command parser
// ----------------------------------------------------------------------------
module spcp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // stalled event holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled event changed");

   // time fields are zero unless update time
   a_time_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != spcp_pkg::EV_TIME) |-> rsp_tdata == 48'd0)
      else $error("time fields set on non time event");

   // no event right after reset
   a_reset_clear: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("event valid after reset");

   // empty result register never back-pressures input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

endmodule

bind star_prefixed_command_parser spcp_checker u_checker (.*);
